// ===== design/spf_pkg.sv =====
package spf_pkg;

    // Phase angles are degrees in signed Q.10.
    localparam int HalfTurn = 184320;
    localparam int FullTurn = 368640;

    // Widths of the payload fields and of the working values.
    localparam int RawPhaseW = 20;
    localparam int PhaseW    = 19;
    localparam int ErrW      = 20;
    localparam int GainW     = 24;
    localparam int ProdW     = ErrW + GainW;
    localparam int DdsW      = 27;
    localparam int IdxW      = 10;
    localparam int CntW      = 11;
    localparam int AmpW      = 32;

    // The integrator is reduced modulo half a turn. Half a turn is 45 * 2^12, so the low
    // twelve bits pass through and only the upper part is reduced modulo 45.
    localparam int ModShift  = 12;
    localparam int ModBase   = 45;
    localparam int ModOffset = ModBase * 365;          // makes the upper part non-negative
    localparam int RecipW    = 17;
    localparam int RecipSh   = 22;
    localparam logic [RecipW-1:0] RecipMul = RecipW'((1 << RecipSh) / ModBase + 1);

    // Configuration register indexes.
    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] RegEnable     = 3'd0;
    localparam logic [CfgIdxW-1:0] RegScanLength = 3'd1;
    localparam logic [CfgIdxW-1:0] RegRefPhase   = 3'd2;
    localparam logic [CfgIdxW-1:0] RegPropGain   = 3'd3;
    localparam logic [CfgIdxW-1:0] RegIntegGain  = 3'd4;
    localparam logic [CfgIdxW-1:0] RegAmpThresh  = 3'd5;

    typedef struct packed {
        logic                     enable;
        logic [CntW-1:0]          scan_length;
        logic signed [PhaseW-1:0] reference_phase;
        logic signed [GainW-1:0]  prop_gain;
        logic signed [GainW-1:0]  integ_gain;
        logic signed [AmpW-1:0]   amp_threshold;
    } spf_cfg_t;

    // One selected entry on its way from the front end to the arithmetic.
    typedef struct packed {
        logic signed [PhaseW-1:0] phase;
        logic [IdxW-1:0]          idx;
    } spf_entry_t;

endpackage

// ===== design/spf_queue.sv =====
module spf_queue #(
    parameter int WIDTH = 29,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0]  count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CntW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/spf_front.sv =====
module spf_front #(
    parameter int SCAN_DEPTH = 1024
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  spf_pkg::spf_cfg_t   cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_scan_start,
    input  logic signed [31:0]  s_amplitude,
    input  logic                s_amp_valid,
    input  logic signed [19:0]  s_raw_phase,
    output logic                q_valid,
    input  logic                q_ready,
    output spf_pkg::spf_entry_t q_entry
);
    import spf_pkg::*;

    localparam logic [CntW-1:0]       CntMax    = '1;
    localparam logic signed [RawPhaseW:0] HalfWide = (RawPhaseW + 1)'(HalfTurn);
    localparam logic signed [RawPhaseW:0] FullWide = (RawPhaseW + 1)'(FullTurn);

    logic [CntW-1:0]          cnt_reg, cnt_next, idx;
    logic                     done_reg, done_now, in_range, qualify, accept;
    logic signed [RawPhaseW:0] ph_wide, ph_wrap;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;

    always_comb begin
        idx      = s_scan_start ? '0 : cnt_reg;
        done_now = s_scan_start ? 1'b0 : done_reg;
        cnt_next = (idx != CntMax) ? idx + 1'b1 : idx;
        in_range = (idx < cfg.scan_length) && (int'(idx) < SCAN_DEPTH);
        qualify  = cfg.enable && !done_now && in_range && s_amp_valid
                   && (s_amplitude > cfg.amp_threshold);

        // A single wrap brings the whole input range into (-180, 180] degrees.
        ph_wide = (RawPhaseW + 1)'(s_raw_phase);
        if (ph_wide > HalfWide) begin
            ph_wrap = ph_wide - FullWide;
        end else if (ph_wide <= -HalfWide) begin
            ph_wrap = ph_wide + FullWide;
        end else begin
            ph_wrap = ph_wide;
        end
    end

    assign q_valid       = accept && qualify;
    assign q_entry.phase = ph_wrap[PhaseW-1:0];
    assign q_entry.idx   = idx[IdxW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (accept) begin
            cnt_reg  <= cnt_next;
            done_reg <= done_now || qualify;
        end
    end

endmodule

// ===== design/spf_back.sv =====
module spf_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  spf_pkg::spf_cfg_t   cfg,
    input  logic                integ_clear,
    input  logic                q_valid,
    output logic                q_ready,
    input  spf_pkg::spf_entry_t q_entry,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [26:0]  m_sample_phase,
    output logic [9:0]          m_entry_used
);
    import spf_pkg::*;

    localparam int SumW = DdsW + 2;
    localparam logic signed [SumW-1:0]   DdsMax = SumW'((1 << (DdsW - 1)) - 1);
    localparam logic signed [SumW-1:0]   DdsMin = -SumW'(1 << (DdsW - 1));
    localparam logic signed [ErrW-1:0]   HalfErr = ErrW'(HalfTurn);
    localparam logic signed [PhaseW-1:0] HalfPh  = PhaseW'(HalfTurn);
    localparam int UpW  = DdsW - ModShift;   // upper part of the integral step
    localparam int YW   = UpW + 1;           // upper part after the offset, unsigned
    localparam int QW   = YW + RecipW - RecipSh;
    localparam int RemW = $clog2(ModBase);
    localparam int RW   = RemW + ModShift;   // integral step reduced modulo half a turn

    logic advance;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, out_valid_reg;

    logic signed [ErrW-1:0]   err1_reg;
    logic signed [ProdW-1:0]  prodp2_reg, prodi2_reg, prodp_next, prodi_next;
    logic signed [DdsW-1:0]   p3_reg, p4_reg, p5_reg, p6_reg;
    logic signed [DdsW-1:0]   x3_reg, x4_reg, x5_reg;
    logic [YW-1:0]            y3_reg, y4_reg, y_next;
    logic signed [YW:0]       y_sum;
    logic [ModShift-1:0]      xlow3_reg, xlow4_reg;
    logic [YW+RecipW-1:0]     qm4_reg;
    logic [YW-1:0]            q45, rem_full;
    logic [RW-1:0]            r5_reg, r_next;
    logic [IdxW-1:0]          idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg, idx6_reg;
    logic [IdxW-1:0]          idx_out_reg;
    logic signed [PhaseW-1:0] integ_reg, ival6_reg, integ_next, m19;
    logic signed [ErrW-1:0]   s_sum, m_wide;
    logic signed [DdsW:0]     t_sum;
    logic signed [SumW-1:0]   dds_sum, dds_next;
    logic signed [DdsW-1:0]   dds_reg;

    // The whole pipeline moves one step whenever the output register can take a result.
    assign advance = !out_valid_reg || m_ready;
    assign q_ready = advance;

    always_comb begin
        prodp_next = err1_reg * cfg.prop_gain;
        prodi_next = err1_reg * cfg.integ_gain;

        // The integral step x floors into 27 bits; its upper part is made non-negative
        // by adding a multiple of 45 so that the modulo below works on unsigned values.
        y_sum  = (YW + 1)'(signed'(prodi2_reg[ProdW-2 -: UpW])) + (YW + 1)'(ModOffset);
        y_next = y_sum[YW-1:0];

        q45      = YW'(qm4_reg[YW+RecipW-1 -: QW]) * YW'(ModBase);
        rem_full = y4_reg - q45;
        r_next   = {rem_full[RemW-1:0], xlow4_reg};

        // Integrator loop: (I + x) truncated modulo half a turn. The floored residue
        // comes from I plus the reduced step; the sign of the full sum decides the
        // truncated form.
        s_sum = ErrW'(integ_reg) + ErrW'(signed'({1'b0, r5_reg}));
        if (s_sum < 0) begin
            m_wide = s_sum + HalfErr;
        end else if (s_sum >= HalfErr) begin
            m_wide = s_sum - HalfErr;
        end else begin
            m_wide = s_sum;
        end
        m19   = m_wide[PhaseW-1:0];
        t_sum = (DdsW + 1)'(x5_reg) + (DdsW + 1)'(integ_reg);
        integ_next = (t_sum[DdsW] && (m19 != '0)) ? m19 - HalfPh : m19;

        dds_sum = SumW'(p6_reg) + SumW'(ival6_reg) + SumW'(HalfTurn);
        if (dds_sum > DdsMax) begin
            dds_next = DdsMax;
        end else if (dds_sum < DdsMin) begin
            dds_next = DdsMin;
        end else begin
            dds_next = dds_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            err1_reg    <= ErrW'(cfg.reference_phase) - ErrW'(q_entry.phase);
            idx1_reg    <= q_entry.idx;
            prodp2_reg  <= prodp_next;
            prodi2_reg  <= prodi_next;
            idx2_reg    <= idx1_reg;
            p3_reg      <= prodp2_reg[ProdW-2:16];
            x3_reg      <= prodi2_reg[ProdW-2:16];
            y3_reg      <= y_next;
            xlow3_reg   <= prodi2_reg[ModShift+15:16];
            idx3_reg    <= idx2_reg;
            qm4_reg     <= y3_reg * RecipMul;
            y4_reg      <= y3_reg;
            xlow4_reg   <= xlow3_reg;
            x4_reg      <= x3_reg;
            p4_reg      <= p3_reg;
            idx4_reg    <= idx3_reg;
            r5_reg      <= r_next;
            x5_reg      <= x4_reg;
            p5_reg      <= p4_reg;
            idx5_reg    <= idx4_reg;
            ival6_reg   <= integ_next;
            p6_reg      <= p5_reg;
            idx6_reg    <= idx5_reg;
            dds_reg     <= dds_next[DdsW-1:0];
            idx_out_reg <= idx6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
        end else begin
            if (advance) begin
                v1_reg        <= q_valid;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                v6_reg        <= v5_reg;
                out_valid_reg <= v6_reg;
            end
            if (integ_clear) begin
                integ_reg <= '0;
            end else if (advance && v5_reg) begin
                integ_reg <= integ_next;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_sample_phase = dds_reg;
    assign m_entry_used   = idx_out_reg;

endmodule

// ===== design/sampling_phase_pi_feedback.sv =====
// Sampling-phase PI feedback. The block takes the bunch entries of a scan one request at a
// time on the s_ channel; s_scan_start marks entry 0 of a new scan, and reset also starts a
// scan. Among the first min(scan_length, SCAN_DEPTH) entries, the first one with amp_valid
// set and an amplitude strictly above amp_threshold is used. Its phase (degrees, signed Q.10)
// is wrapped once into (-180, 180], the error against reference_phase drives a proportional
// term and an integrator (gains signed Q.16, products floored by 2^16, integrator truncated
// modulo 180 degrees), and P + I + 180 degrees leaves on the m_ channel as m_sample_phase
// together with the entry's index in m_entry_used. At most one result request comes out per
// scan. With enable low, every accepted entry clears the integrator and nothing is emitted.
// Throughput is one entry per clock cycle, sustained while the m_ channel does not stall,
// also when every entry produces a result. An accepted entry is written into the four-deep
// queue between the classifying front end and the arithmetic at the accepting edge, and the
// seven-stage pipeline behind it (error, two 20x24 multiplies, splitting of the integral
// step, a reciprocal multiply for the modulo-45 reduction, the remainder, the integrator
// update, and the output register) takes it from the queue. The integrator update is the
// only loop and closes in a single stage. A stalled m_ channel halts the arithmetic; the
// front end keeps accepting entries until the queue fills.
// Configuration is written through the cfg_ channel (always ready) while the block is idle.
// Indexes: 0 enable, 1 scan_length, 2 reference_phase, 3 prop_gain, 4 integ_gain,
// 5 amp_threshold; writes to other indexes are ignored.
module sampling_phase_pi_feedback #(
    parameter int SCAN_DEPTH  = 1024,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_scan_start,
    input  logic signed [31:0]  s_amplitude,
    input  logic                s_amp_valid,
    input  logic signed [19:0]  s_raw_phase,
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [26:0]  m_sample_phase,
    output logic [9:0]          m_entry_used,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    import spf_pkg::*;

    spf_cfg_t   cfg_reg;
    spf_entry_t push_entry, pop_entry;
    logic       push_valid, push_ready, pop_valid, pop_ready;
    logic       integ_clear;

    // The configuration port never stalls.
    assign cfg_ready = 1'b1;

    // Every entry accepted while the feedback is off clears the integrator; nothing is in the
    // arithmetic then, as the user must change configuration only while idle (not enforced).
    assign integ_clear = s_valid && s_ready && !cfg_reg.enable;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable          <= 1'b1;
            cfg_reg.scan_length     <= '0;
            cfg_reg.reference_phase <= '0;
            cfg_reg.prop_gain       <= GainW'(6554);
            cfg_reg.integ_gain      <= GainW'(65536);
            cfg_reg.amp_threshold   <= AmpW'(400);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                RegEnable:     cfg_reg.enable          <= cfg_data[0];
                RegScanLength: cfg_reg.scan_length     <= cfg_data[CntW-1:0];
                RegRefPhase:   cfg_reg.reference_phase <= cfg_data[PhaseW-1:0];
                RegPropGain:   cfg_reg.prop_gain       <= cfg_data[GainW-1:0];
                RegIntegGain:  cfg_reg.integ_gain      <= cfg_data[GainW-1:0];
                RegAmpThresh:  cfg_reg.amp_threshold   <= cfg_data[AmpW-1:0];
                default: begin
                end
            endcase
        end
    end

    // The front end tracks the scan position and forwards only the selected entry.
    spf_front #(
        .SCAN_DEPTH(SCAN_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_scan_start (s_scan_start),
        .s_amplitude  (s_amplitude),
        .s_amp_valid  (s_amp_valid),
        .s_raw_phase  (s_raw_phase),
        .q_valid      (push_valid),
        .q_ready      (push_ready),
        .q_entry      (push_entry)
    );

    // The queue lets the front end keep going while the output side is stalled.
    spf_queue #(
        .WIDTH($bits(spf_entry_t)),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_entry)
    );

    // The back end runs the PI arithmetic and owns the integrator.
    spf_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .integ_clear    (integ_clear),
        .q_valid        (pop_valid),
        .q_ready        (pop_ready),
        .q_entry        (pop_entry),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_phase (m_sample_phase),
        .m_entry_used   (m_entry_used)
    );

endmodule

// ===== tb/spf_pi_checker.sv =====
`timescale 1ns / 1ps

module spf_pi_checker #(
    parameter int SCAN_DEPTH = 1024
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_scan_start,
    input  logic signed [31:0]    s_amplitude,
    input  logic                  s_amp_valid,
    input  logic signed [19:0]    s_raw_phase,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic signed [26:0]    m_sample_phase,
    input  logic [9:0]            m_entry_used,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    output int                    fail_count,
    output int                    pending_results
);
    import spf_pkg::*;

    typedef struct {
        logic signed [DdsW-1:0] sample_phase;
        logic [IdxW-1:0]        entry_used;
    } phase_update_t;

    // Updates still owed by the block, oldest first.
    phase_update_t owed_updates[$];

    // Register copy.
    logic                      fb_enable;
    logic [CntW-1:0]           scan_len;
    logic signed [PhaseW-1:0]  target_phase;
    logic signed [GainW-1:0]   kp_gain;
    logic signed [GainW-1:0]   ki_gain;
    logic signed [AmpW-1:0]    amp_floor;

    // Loop state.
    logic signed [PhaseW-1:0]  integ_acc;
    logic [CntW-1:0]           next_index;
    logic                      scan_closed;

    task automatic flag_problem(input string what);
        fail_count++;
        if (fail_count <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // Advances the scan state by one entry and returns 1 when the entry triggers an update.
    function automatic bit track_entry(input logic start, input logic signed [AmpW-1:0] amp,
                                       input logic amp_ok,
                                       input logic signed [RawPhaseW-1:0] raw,
                                       output phase_update_t upd);
        logic [CntW-1:0] idx;
        int unsigned     window;
        longint          phase, err, prop, integ, dds;
        upd.sample_phase = '0;
        upd.entry_used   = '0;
        if (start) begin
            next_index  = '0;
            scan_closed = 1'b0;
        end
        idx = next_index;
        if (next_index != '1) begin
            next_index = next_index + 1'b1;
        end
        if (!fb_enable) begin
            integ_acc = '0;
            return 1'b0;
        end
        window = (scan_len > SCAN_DEPTH) ? SCAN_DEPTH : scan_len;
        if (scan_closed || idx >= window) begin
            return 1'b0;
        end
        if (!amp_ok || !(longint'(amp) > longint'(amp_floor))) begin
            return 1'b0;
        end
        phase = longint'(raw);
        if (phase > HalfTurn) begin
            phase -= FullTurn;
        end else if (phase <= -HalfTurn) begin
            phase += FullTurn;
        end
        err   = longint'(target_phase) - phase;
        prop  = (err * longint'(kp_gain)) >>> 16;
        integ = (longint'(integ_acc) + ((err * longint'(ki_gain)) >>> 16)) % HalfTurn;
        integ_acc = PhaseW'(integ);
        dds = prop + integ + HalfTurn;
        if (dds > 67108863) begin
            dds = 67108863;
        end
        if (dds < -67108864) begin
            dds = -67108864;
        end
        upd.sample_phase = DdsW'(dds);
        upd.entry_used   = idx[IdxW-1:0];
        scan_closed = 1'b1;
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        phase_update_t want;
        phase_update_t got;
        if (!aresetn) begin
            fb_enable    = 1'b1;
            scan_len     = '0;
            target_phase = '0;
            kp_gain      = GainW'(6554);
            ki_gain      = GainW'(65536);
            amp_floor    = AmpW'(400);
            integ_acc    = '0;
            next_index   = '0;
            scan_closed  = 1'b0;
            owed_updates.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    RegEnable:     fb_enable    = cfg_data[0];
                    RegScanLength: scan_len     = cfg_data[CntW-1:0];
                    RegRefPhase:   target_phase = cfg_data[PhaseW-1:0];
                    RegPropGain:   kp_gain      = cfg_data[GainW-1:0];
                    RegIntegGain:  ki_gain      = cfg_data[GainW-1:0];
                    RegAmpThresh:  amp_floor    = cfg_data[AmpW-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (track_entry(s_scan_start, s_amplitude, s_amp_valid, s_raw_phase, want)) begin
                    owed_updates.push_back(want);
                end
            end
            if (m_valid && m_ready) begin
                got.sample_phase = m_sample_phase;
                got.entry_used   = m_entry_used;
                if (owed_updates.size() == 0) begin
                    flag_problem($sformatf(
                        "unexpected result: sample_phase %0d entry_used %0d",
                        got.sample_phase, got.entry_used));
                end else begin
                    want = owed_updates.pop_front();
                    if (got.sample_phase !== want.sample_phase ||
                        got.entry_used !== want.entry_used) begin
                        flag_problem($sformatf(
                            "mismatch: sample_phase %0d (expected %0d), %s %0d (expected %0d)",
                            got.sample_phase, want.sample_phase, "entry_used",
                            got.entry_used, want.entry_used));
                    end
                end
            end
        end
        pending_results = owed_updates.size();
    end

endmodule

// ===== tb/tb_sampling_phase_pi_feedback.sv =====
`timescale 1ns / 1ps

module tb_sampling_phase_pi_feedback;
    import spf_pkg::*;

    localparam int     RandomItems = 400;
    localparam int     CycleLimit  = 800000;
    localparam longint AmpMax      = 64'sd2147483647;
    localparam longint AmpMin      = -64'sd2147483648;
    // An index past the register map; the block must ignore writes to it.
    localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic               s_scan_start   = 1'b0;
    logic signed [31:0] s_amplitude    = '0;
    logic               s_amp_valid    = 1'b0;
    logic signed [19:0] s_raw_phase    = '0;
    logic               m_valid;
    logic               m_ready        = 1'b1;
    logic signed [26:0] m_sample_phase;
    logic [9:0]         m_entry_used;
    logic               cfg_valid      = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index      = '0;
    logic [31:0]        cfg_data       = '0;

    int fail_count;
    int pending_results;

    // Idling on both channels is switched off for the final stretch of the run.
    bit idle_on = 1'b1;
    int ready_left = 0;
    int cycle_count = 0;

    // Mirror of the programmed amplitude threshold, used to aim the random amplitudes just
    // above or just below the qualifying limit, and of the scan length, used to size scans.
    longint cur_thr = 400;
    int     cur_len = 0;

    sampling_phase_pi_feedback uut (.*);

    spf_pi_checker feedback_check (.*);

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("Run stopped after %0d cycles without finishing", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side back-pressure. The receiver alternates between ready stretches and stalls of
    // random length, so stalls land on every pipeline stage over the run. Once idling is
    // switched off, m_ready simply stays high.
    always @(posedge aclk) begin
        if (!idle_on) begin
            m_ready <= 1'b1;
        end else if (ready_left != 0) begin
            ready_left <= ready_left - 1;
        end else if ($urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            ready_left <= $urandom_range(0, 15);
        end else begin
            m_ready    <= 1'b1;
            ready_left <= $urandom_range(0, 30);
        end
    end

    // Presents one configuration request and waits for its handshake. cfg_valid is left
    // high so that back-to-back writes never lower and raise it in the same step; the
    // caller drops it after the last write of a batch.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes the whole register map. Only called while the block is idle.
    task automatic program_block(input logic en, input int len, input int ref_deg,
                                 input int kp, input int ki, input longint thr);
        write_reg(RegEnable,     32'(en));
        write_reg(RegScanLength, 32'(len));
        write_reg(RegRefPhase,   32'(ref_deg));
        write_reg(RegPropGain,   32'(kp));
        write_reg(RegIntegGain,  32'(ki));
        write_reg(RegAmpThresh,  32'(thr));
        cfg_valid <= 1'b0;
        cur_thr = thr;
        cur_len = len;
    endtask

    // Sends one entry request. With idling on, a random gap may come first; without a gap,
    // valid stays high straight from the previous request.
    task automatic send_entry(input logic start, input logic signed [AmpW-1:0] amp,
                              input logic amp_ok, input logic signed [RawPhaseW-1:0] raw);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 16);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_scan_start <= start;
        s_amplitude  <= amp;
        s_amp_valid  <= amp_ok;
        s_raw_phase  <= raw;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stops sending and waits until every predicted update has come out, then gives the
    // pipeline time to settle entries that were never going to produce a result.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results != 0);
        repeat (16) @(posedge aclk);
    endtask

    // Picks an amplitude just above the threshold when asked to qualify, at or below it
    // otherwise; now and then a fully random word so every bit toggles.
    function automatic logic signed [AmpW-1:0] pick_amplitude(input longint thr,
                                                             input bit above);
        longint v;
        if ($urandom_range(0, 4) == 0) begin
            return $urandom;
        end
        if (above) begin
            v = thr + longint'($urandom_range(1, 1000));
        end else begin
            v = thr - longint'($urandom_range(0, 1000));
        end
        if (v > AmpMax) begin
            v = AmpMax;
        end
        if (v < AmpMin) begin
            v = AmpMin;
        end
        return AmpW'(v);
    endfunction

    // Raw phases: mostly uniform over the full 20-bit range, with extra weight on the
    // edges of the wrap window and the ends of the field.
    function automatic logic signed [RawPhaseW-1:0] pick_phase();
        case ($urandom_range(0, 11))
            0: return RawPhaseW'(HalfTurn);
            1: return RawPhaseW'(-HalfTurn);
            2: return RawPhaseW'(HalfTurn + 1);
            3: return RawPhaseW'(-HalfTurn + 1);
            4: return RawPhaseW'(524287);
            5: return RawPhaseW'(-524288);
            default: return RawPhaseW'($urandom);
        endcase
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 5))
            0: return 8388607;
            1: return -8388608;
            2: return 0;
            3: return int'($urandom_range(0, 131072)) - 65536;
            default: return int'($signed(GainW'($urandom)));
        endcase
    endfunction

    // Sends one scan of entries. Entries before first_hit carry amp_valid low so the
    // first usable entry sits exactly where the caller wants it; from there on each entry
    // aims to qualify with the given percentage. Ordinary scans (first_hit of zero) also
    // get the occasional missing scan start or an extra one in the middle.
    task automatic run_scan(input int entries, input int hit_pct, input int first_hit);
        bit   above;
        logic start;
        logic amp_ok;
        for (int k = 0; k < entries; k++) begin
            above = (k >= first_hit) && ($urandom_range(0, 99) < hit_pct);
            if (k == 0) begin
                start = (first_hit > 0) || ($urandom_range(0, 9) != 0);
            end else begin
                start = (first_hit == 0) && ($urandom_range(0, 49) == 0);
            end
            if (k < first_hit) begin
                amp_ok = 1'b0;
            end else if (above) begin
                amp_ok = ($urandom_range(0, 9) != 0);
            end else begin
                amp_ok = $urandom_range(0, 1);
            end
            send_entry(start, pick_amplitude(cur_thr, above), amp_ok, pick_phase());
        end
    endtask

    initial begin
        int     random_items;
        int     phase_end;
        int     window;
        int     entries;
        int     settle;
        logic   en;
        int     len;
        int     ref_deg;
        longint thr;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // A write to an unmapped index must leave the register map untouched.
        write_reg(RegUnused, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        @(posedge aclk);

        // Reset counts as a scan start, so the first entries here have no scan start flag
        // and still begin at index zero. Covers amp_valid low, an amplitude equal to the
        // threshold, the downward wrap, and an entry after the scan has already fired.
        program_block(1'b1, 4, 0, 6554, 65536, 400);
        send_entry(1'b0, 32'sd1000, 1'b0, 20'sd1000);
        send_entry(1'b0, 32'sd400, 1'b1, 20'sd1000);
        send_entry(1'b0, 32'sd401, 1'b1, 20'sd524287);
        send_entry(1'b0, 32'sd5000, 1'b1, 20'sd0);
        // Amplitude extremes and the upward wrap.
        send_entry(1'b1, 32'sh8000_0000, 1'b1, 20'sd0);
        send_entry(1'b0, 32'sh7FFF_FFFF, 1'b1, -20'sd524288);
        // The edges of the wrap window: +180 stays, -180 turns into +180.
        send_entry(1'b1, 32'sd500, 1'b1, RawPhaseW'(HalfTurn));
        send_entry(1'b1, 32'sd500, 1'b1, RawPhaseW'(-HalfTurn));
        send_entry(1'b1, 32'sd500, 1'b1, RawPhaseW'(HalfTurn + 1));
        send_entry(1'b1, 32'sd500, 1'b1, RawPhaseW'(-HalfTurn + 1));
        // A qualifying entry just past the searched window must be ignored.
        send_entry(1'b1, 32'sd0, 1'b0, 20'sd0);
        send_entry(1'b0, 32'sd0, 1'b0, 20'sd0);
        send_entry(1'b0, 32'sd0, 1'b0, 20'sd0);
        send_entry(1'b0, 32'sd0, 1'b0, 20'sd0);
        send_entry(1'b0, 32'sd900, 1'b1, 20'sd7);
        drain_results();

        // Largest positive gains and reference with the lowest threshold.
        program_block(1'b1, 1, HalfTurn, 8388607, 8388607, AmpMin);
        send_entry(1'b1, 32'sh8000_0000, 1'b1, -20'sd524288);
        send_entry(1'b1, 32'sh8000_0001, 1'b1, -20'sd524288);
        send_entry(1'b0, 32'sd5, 1'b1, 20'sd0);
        send_entry(1'b1, 32'sd5, 1'b1, 20'sd524287);
        send_entry(1'b1, 32'sd5, 1'b1, RawPhaseW'(-HalfTurn + 1));
        drain_results();

        // The highest threshold lets nothing through.
        program_block(1'b1, 2, -HalfTurn, -8388608, -8388608, AmpMax);
        send_entry(1'b1, 32'sh7FFF_FFFF, 1'b1, 20'sd524287);
        send_entry(1'b0, 32'sh7FFF_FFFF, 1'b1, 20'sd1);
        drain_results();

        // Most negative gains and reference.
        program_block(1'b1, 2, -HalfTurn, -8388608, -8388608, -1);
        send_entry(1'b1, 32'sd0, 1'b1, 20'sd524287);
        send_entry(1'b1, 32'sd0, 1'b1, -20'sd524288);
        drain_results();

        // Disabled: qualifying entries produce nothing and the integrator is cleared.
        program_block(1'b0, 2, -HalfTurn, -8388608, -8388608, -1);
        send_entry(1'b1, 32'sd100, 1'b1, 20'sd1000);
        send_entry(1'b0, 32'sd100, 1'b1, 20'sd1000);
        drain_results();

        // A scan length of zero searches nothing.
        program_block(1'b1, 0, 0, 6554, 65536, 400);
        send_entry(1'b1, 32'sd1000, 1'b1, 20'sd0);
        drain_results();

        // Back on: the first update must start from a cleared integrator.
        program_block(1'b1, 4, 0, 6554, 65536, 400);
        send_entry(1'b1, 32'sd1000, 1'b1, 20'sd1000);
        drain_results();

        // Longer scans. The first usable entry sits deep in the window so that the upper
        // bits of entry_used toggle; a scan length beyond the depth is clamped to it.
        program_block(1'b1, 1024, 1000, 30000, 20000, 0);
        run_scan(150, 60, 130);
        drain_results();
        program_block(1'b1, 2047, 1000, 30000, 20000, 0);
        run_scan(40, 100, 30);
        drain_results();

        // Random phases. Every phase starts from an idle block with a fresh register map,
        // which also gives the full-drain pause between phases. Settings lean toward short
        // windows so that most scans end in an update, with the extremes mixed in.
        random_items = 0;
        while (random_items < RandomItems) begin
            drain_results();
            if (random_items >= RandomItems - 120) begin
                idle_on = 1'b0;
            end
            en = ($urandom_range(0, 5) != 0);
            case ($urandom_range(0, 7))
                0: len = 0;
                1: len = 1;
                2: len = 2047;
                3: len = 1024;
                default: len = $urandom_range(2, 20);
            endcase
            case ($urandom_range(0, 3))
                0: ref_deg = HalfTurn;
                1: ref_deg = -HalfTurn;
                default: ref_deg = int'($urandom_range(0, 2 * HalfTurn)) - HalfTurn;
            endcase
            case ($urandom_range(0, 9))
                0: thr = AmpMin;
                1: thr = AmpMax;
                default: thr = longint'($urandom_range(0, 2000)) - 1000;
            endcase
            program_block(en, len, ref_deg, pick_gain(), pick_gain(), thr);
            phase_end = random_items + $urandom_range(30, 60);
            while (random_items < phase_end) begin
                window  = (cur_len > 1024) ? 1024 : cur_len;
                entries = $urandom_range(1, ((window < 20) ? window : 20) + 3);
                run_scan(entries, $urandom_range(15, 60), 0);
                random_items += entries;
            end
        end

        // End of stimulus: wait for the last updates, with a bound of its own, then let
        // the pipeline run out before the verdict.
        s_valid <= 1'b0;
        settle = 0;
        while (pending_results != 0 && settle < 5000) begin
            @(posedge aclk);
            settle++;
        end
        repeat (20) @(posedge aclk);
        if (pending_results != 0) begin
            $display("%0d expected results never arrived", pending_results);
        end
        if (fail_count == 0 && pending_results == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
